// ===== sv/dfr_pkg.sv =====
`default_nettype none

package dfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 8;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_START_SYMBOL = cfg_index_t'(0);
    localparam cfg_index_t REG_END_SYMBOL   = cfg_index_t'(1);

    // Delimiter values after reset.
    localparam byte_t START_SYMBOL_RESET = byte_t'(60);
    localparam byte_t END_SYMBOL_RESET   = byte_t'(62);

endpackage

`default_nettype wire

// ===== sv/dfr_if.sv =====
`default_nettype none

// Received byte channel.
interface dfr_rx_if;
    logic            valid;
    logic            ready;
    dfr_pkg::byte_t  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Emitted frame byte channel.
interface dfr_frame_if;
    logic            valid;
    logic            ready;
    dfr_pkg::byte_t  frame_byte;
    logic            is_type;
    logic            last;

    modport source (output valid, output frame_byte, output is_type, output last, input ready);
    modport sink   (input valid, input frame_byte, input is_type, input last, output ready);
endinterface

// Configuration register write channel.
interface dfr_cfg_if;
    logic                 valid;
    logic                 ready;
    dfr_pkg::cfg_index_t  index;
    dfr_pkg::byte_t       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/delimited_frame_receiver_top.sv =====
// Receive: one rx byte is taken per cycle while no frame is being emitted.
// Emit: a frame of N stored bytes leaves at one byte per cycle while the sink is ready,
// and the input is held off until the last frame byte is loaded into the output register.
// After the end symbol, the type byte goes to the read data register, then the output register.
// Reset (rst_n, asynchronous, active low) returns to idle and restores both delimiters;
// the frame store is not cleared, since only bytes written in the current frame are read.
`default_nettype none

module delimited_frame_receiver_top #(
    parameter int MAX_FRAME_LENGTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dfr_rx_if.sink     rx,
    dfr_frame_if.source frame,
    dfr_cfg_if.sink    cfg
);

    import dfr_pkg::*;

    // The store holds at most MAX_FRAME_LENGTH-1 payload bytes. The fill count must also
    // be able to hold the depth itself, so it can be one bit wider than an address.
    localparam int DEPTH  = MAX_FRAME_LENGTH - 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_FRAME_LENGTH);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // ACCEPT takes rx bytes; EMIT streams the stored frame to the output register.
    typedef enum logic {
        ST_ACCEPT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   receiving_reg;
    cnt_t   fill_count_reg;
    addr_t  emit_ptr_reg;
    addr_t  last_idx_reg;

    byte_t  start_symbol_reg;
    byte_t  end_symbol_reg;

    // Output register: it holds a finished byte until the sink takes it, so the
    // receive side can keep accepting rx bytes meanwhile.
    logic   out_valid_reg;
    byte_t  out_byte_reg;
    logic   out_is_type_reg;
    logic   out_last_reg;

    // Frame store, a synchronous single-read memory with registered read data.
    byte_t  frame_store [DEPTH];
    byte_t  rd_data_reg;

    logic   rx_xfer;
    logic   out_load;
    logic   wr_en;
    addr_t  wr_addr;
    logic   rd_en;
    addr_t  rd_addr;
    logic   is_end;
    logic   is_start;
    logic   store_full;

    assign rx.ready  = (state_reg == ST_ACCEPT);
    assign rx_xfer   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.is_type    = out_is_type_reg;
    assign frame.last       = out_last_reg;

    // While receiving, a byte equal to both delimiters counts as the end symbol,
    // which the priority of is_end over is_start below gives.
    assign is_end     = (rx.rx_byte == end_symbol_reg);
    assign is_start   = (rx.rx_byte == start_symbol_reg);
    assign store_full = (fill_count_reg >= cnt_t'(DEPTH));

    // The output register takes the next byte when it is empty or being drained.
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || frame.ready);

    // Memory port control. Writes happen only while receiving in ACCEPT and reads only
    // on the end symbol or during EMIT, and rx.ready is low in EMIT, so a read and a
    // write never touch the store in the same cycle.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_count_reg[ADDR_W-1:0];
        rd_en   = 1'b0;
        rd_addr = '0;
        if (rx_xfer && receiving_reg)
        begin
            if (is_end)
            begin
                // Fetch the type byte right away so it is ready for the output register in EMIT.
                rd_en = (fill_count_reg != '0);
            end
            else if (!is_start && !store_full)
            begin
                wr_en = 1'b1;
            end
        end
        else if (out_load && (emit_ptr_reg != last_idx_reg))
        begin
            // Prefetch the following byte while the current one is loaded.
            rd_en   = 1'b1;
            rd_addr = emit_ptr_reg + addr_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_store[wr_addr] <= rx.rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_store[rd_addr];
        end
    end

    // Configuration writes; indexes beyond the two registers are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_symbol_reg <= START_SYMBOL_RESET;
            end_symbol_reg   <= END_SYMBOL_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_START_SYMBOL: start_symbol_reg <= cfg.data;
                REG_END_SYMBOL:   end_symbol_reg   <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Frame state machine and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_ACCEPT;
            receiving_reg   <= 1'b0;
            fill_count_reg  <= '0;
            emit_ptr_reg    <= '0;
            last_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            out_is_type_reg <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            // A drained output register empties unless a new byte is loaded into it.
            if (frame.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_ACCEPT:
                begin
                    if (rx_xfer)
                    begin
                        if (!receiving_reg)
                        begin
                            if (is_start)
                            begin
                                receiving_reg  <= 1'b1;
                                fill_count_reg <= '0;
                            end
                        end
                        else if (is_end)
                        begin
                            // An empty frame emits nothing and simply returns to idle.
                            if (fill_count_reg != '0)
                            begin
                                state_reg    <= ST_EMIT;
                                emit_ptr_reg <= '0;
                                last_idx_reg <= addr_t'(fill_count_reg - cnt_t'(1));
                            end
                            receiving_reg  <= 1'b0;
                            fill_count_reg <= '0;
                        end
                        else if (is_start)
                        begin
                            fill_count_reg <= '0;
                        end
                        else if (!store_full)
                        begin
                            fill_count_reg <= fill_count_reg + cnt_t'(1);
                        end
                        else
                        begin
                            // Overlong frame: drop it and the byte, back to idle.
                            receiving_reg  <= 1'b0;
                            fill_count_reg <= '0;
                        end
                    end
                end

                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_byte_reg    <= rd_data_reg;
                        out_is_type_reg <= (emit_ptr_reg == '0);
                        out_last_reg    <= (emit_ptr_reg == last_idx_reg);
                        if (emit_ptr_reg == last_idx_reg)
                        begin
                            state_reg <= ST_ACCEPT;
                        end
                        else
                        begin
                            emit_ptr_reg <= emit_ptr_reg + addr_t'(1);
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_ACCEPT;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The fill count never runs past the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= cnt_t'(DEPTH))
        else $error("fill count exceeds frame store depth");

    // A store write only happens while a frame is being received.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (receiving_reg && state_reg == ST_ACCEPT))
        else $error("frame store written outside of reception");

    // Every store read is followed by a cycle in EMIT that consumes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_EMIT))
        else $error("store read issued without emission following");

    // Emission always starts from idle reception.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !receiving_reg)
        else $error("receiving while emitting a frame");

    // A pending type byte of a multi-byte frame means the rest is still being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_is_type_reg && !out_last_reg) |-> (state_reg == ST_EMIT))
        else $error("frame emission ended before its last byte");
`endif

endmodule

`default_nettype wire
